// ===== rtl/core/lpr_pkg.sv =====
// lpr_pkg: shared types and constants of the lru page replacement block
// request and response structs, cell state and control structs, status codes
// no dependencies
`default_nettype none

package lpr_pkg;

  localparam int unsigned ENTRIES = 8;
  localparam int unsigned PAGE_W  = 16;
  localparam int unsigned STAT_W  = 3;

  localparam logic [PAGE_W-1:0] NO_PAGE = '1;

  localparam logic KIND_TOUCH = 1'b0;
  localparam logic KIND_EVICT = 1'b1;

  localparam logic [STAT_W-1:0] STAT_HIT     = 3'd0;
  localparam logic [STAT_W-1:0] STAT_INSERT  = 3'd1;
  localparam logic [STAT_W-1:0] STAT_DROPPED = 3'd2;
  localparam logic [STAT_W-1:0] STAT_EVICTED = 3'd3;
  localparam logic [STAT_W-1:0] STAT_EMPTY   = 3'd4;

  typedef struct packed {
    logic              kind;
    logic [PAGE_W-1:0] page_id;
  } req_t;

  typedef struct packed {
    logic [PAGE_W-1:0] page_out;
    logic [STAT_W-1:0] status;
  } rsp_t;

  // contents of one cell
  typedef struct packed {
    logic              valid;
    logic [PAGE_W-1:0] page;
  } cell_t;

  // control broadcast to every cell
  typedef struct packed {
    logic              en;
    logic              touch;
    logic              insert;
    logic              shift_all;
    logic [PAGE_W-1:0] page;
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/core/lpr_cell.sv =====
// lpr_cell: one slot of the recency list
// compares its page, passes the hit chain on and takes its right neighbour on a shift
// depends on lpr_pkg
`default_nettype none

module lpr_cell (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire lpr_pkg::cell_ctrl_t ctrl_i,
  input  wire logic               prev_valid_i,
  input  wire lpr_pkg::cell_t     next_i,
  input  wire logic               hit_i,
  output logic                    hit_o,
  output lpr_pkg::cell_t          cell_o
);

  logic                        valid_q, valid_d;
  logic [lpr_pkg::PAGE_W-1:0]  page_q, page_d;
  logic                        hit_here;
  logic                        shift;

  assign hit_here = ctrl_i.touch & valid_q & (page_q == ctrl_i.page);
  assign hit_o    = hit_i | hit_here;
  // every valid cell at or after the hit (or all of them) closes the gap
  assign shift    = ctrl_i.en & valid_q & (ctrl_i.shift_all | hit_o);

  always_comb begin
    valid_d = valid_q;
    page_d  = page_q;
    if (shift) begin
      if (next_i.valid) begin
        page_d = next_i.page;
      end else if (ctrl_i.touch) begin
        page_d = ctrl_i.page;
      end else begin
        valid_d = 1'b0;
      end
    end else if (ctrl_i.en & ctrl_i.insert & ~valid_q & prev_valid_i) begin
      valid_d = 1'b1;
      page_d  = ctrl_i.page;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    page_q <= page_d;
  end

  assign cell_o.valid = valid_q;
  assign cell_o.page  = page_q;

endmodule

`default_nettype wire

// ===== rtl/core/lru_page_replacement_top.sv =====
// lru_page_replacement_top: least recently used page list as a row of cells
// one request in, one response out, through a registered output stage
// depends on lpr_pkg and lpr_cell
//
//  channel | handshake                 | payload
//  --------+---------------------------+---------------------------
//  in      | in_valid_i / in_stall_o   | in_req_i  (kind, page_id)
//  out     | out_valid_o / out_stall_i | out_rsp_o (page_out, status)
//
// one request per cycle when not stalled: all cells compare in parallel and shift in
// the same cycle, and the registered response shows in the cycle after acceptance
// the hit search ripples through the row of cells, which sets the cycle time
// reset empties the list (valid bits only); page contents are not reset
// while a response is held by out_stall_i, no new request is taken
`default_nettype none

module lru_page_replacement_top (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  wire lpr_pkg::req_t in_req_i,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  output lpr_pkg::rsp_t      out_rsp_o
);

  localparam int unsigned N = lpr_pkg::ENTRIES;

  lpr_pkg::cell_t      cells [N];
  logic [N:0]          hit_chain;
  lpr_pkg::cell_ctrl_t ctrl;

  logic          accept;
  logic          touch;
  logic          full;
  logic          hit_any;
  logic          out_valid_q;
  lpr_pkg::rsp_t rsp_q, rsp_d;

  // response register frees up when taken
  assign in_stall_o = out_valid_q & out_stall_i;
  assign accept     = in_valid_i & ~in_stall_o;

  assign touch   = (in_req_i.kind == lpr_pkg::KIND_TOUCH);
  assign full    = cells[N-1].valid;
  assign hit_any = hit_chain[N];

  // broadcast control
  assign ctrl.en        = accept;
  assign ctrl.touch     = touch;
  assign ctrl.page      = in_req_i.page_id;
  assign ctrl.insert    = touch & ~hit_any & ~full;
  assign ctrl.shift_all = (~touch & cells[0].valid) | (touch & ~hit_any & full);

  assign hit_chain[0] = 1'b0;

  for (genvar i = 0; i < N; i++) begin : g_cell
    lpr_pkg::cell_t next_cell;
    logic           prev_valid;

    if (i == N - 1) begin : g_last
      assign next_cell = '0;
    end else begin : g_mid
      assign next_cell = cells[i+1];
    end

    if (i == 0) begin : g_first
      assign prev_valid = 1'b1;
    end else begin : g_rest
      assign prev_valid = cells[i-1].valid;
    end

    lpr_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl),
      .prev_valid_i(prev_valid),
      .next_i      (next_cell),
      .hit_i       (hit_chain[i]),
      .hit_o       (hit_chain[i+1]),
      .cell_o      (cells[i])
    );
  end

  // response for the current request
  always_comb begin
    rsp_d.page_out = lpr_pkg::NO_PAGE;
    rsp_d.status   = lpr_pkg::STAT_EMPTY;
    if (touch) begin
      if (hit_any) begin
        rsp_d.status = lpr_pkg::STAT_HIT;
      end else if (!full) begin
        rsp_d.status = lpr_pkg::STAT_INSERT;
      end else begin
        rsp_d.status   = lpr_pkg::STAT_DROPPED;
        rsp_d.page_out = cells[0].page;
      end
    end else if (cells[0].valid) begin
      rsp_d.status   = lpr_pkg::STAT_EVICTED;
      rsp_d.page_out = cells[0].page;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      rsp_q <= rsp_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = rsp_q;

endmodule

`default_nettype wire
